// ----- rtl/bba_pkg.sv -----
// bba_pkg: shared constants for the bitmap block allocator
// status codes, opcodes, field widths and parameter defaults
// no dependencies
package bba_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int WORD_BITS_DEF  = 32;

    localparam int TOTAL_W     = 13;
    localparam int BLK_NUM_W   = 12;
    localparam int STATUS_W    = 2;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_BLOCKS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE  = 2'd3;

    localparam logic [0:0] REG_TOTAL_BLOCKS = 1'b0;

endpackage

// ----- rtl/bitmap_block_allocator.sv -----
// bitmap_block_allocator: first-fit free block allocator over a used/free bitmap
// bitmap held in one synchronous memory, read-modify-write by a small sequencer
// depends on bba_pkg
//
// usage:
//   request word: i_opcode, i_block_number; taken at a clock edge with start high
//   and busy low. result word: o_result_block, o_status, valid for one cycle while
//   o_done is high; the receiver cannot stall, so it must take every strobe.
//   config: apb port, total_blocks at byte address 0, written by the user only while idle; not enforced.
// timing:
//   allocate scans the bitmap one memory word per cycle from word 0 up to the
//   first word with a free bit or the last word below the block count; o_done
//   rises at the same edge as busy falls.
//   free reads one word, writes it back unless already free; o_done rises in the next cycle.
//   a free out of range raises o_done at the accepting edge, no memory access.
//   a new request may be taken in the cycle o_done is high.
// reset:
//   synchronous, active low; total_blocks returns to 4096, then a clearing pass
//   writes zero to every bitmap word, one per cycle, with busy high. apb writes
//   are taken during the pass.
// WORD_BITS must be a power of two.
module bitmap_block_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bba_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bba_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bba_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_opcode,
    input  logic [bba_pkg::BLK_NUM_W-1:0]   i_block_number,
    output logic                            o_done,
    output logic [bba_pkg::BLK_NUM_W-1:0]   o_result_block,
    output logic [bba_pkg::STATUS_W-1:0]    o_status
);

    localparam int WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int BLK_W  = WA + BIT_W;
    localparam int CW     = (bba_pkg::TOTAL_W > BLK_W + 1) ? bba_pkg::TOTAL_W : BLK_W + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FCHK  = 2'd3;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic [1:0]                        r_state, n_state;
    logic [WA-1:0]                     r_clr, n_clr;
    logic [WA-1:0]                     r_chk, n_chk;
    logic [BIT_W-1:0]                  r_bit, n_bit;
    logic [bba_pkg::TOTAL_W-1:0]       r_total;
    logic                              r_done, n_done;
    logic [bba_pkg::BLK_NUM_W-1:0]     r_result, n_result;
    logic [bba_pkg::STATUS_W-1:0]      r_status, n_status;

    logic                   mem_we, mem_re;
    logic [WA-1:0]          mem_wa, mem_ra;
    logic [WORD_BITS-1:0]   mem_wd;

    logic [CW-1:0]          count;
    logic [BLK_W-1:0]       base;
    logic signed [CW:0]     rem;
    logic [WORD_BITS-1:0]   valid_m, free_v;
    logic                   found, last;
    logic [BIT_W-1:0]       idx;
    logic [BLK_W-1:0]       req_blk;
    logic                   accept, cfg_wr;

    assign pready = 1'b1;
    assign prdata = bba_pkg::APB_DATA_W'(r_total);
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[bba_pkg::APB_ADDR_W-1:2] == bba_pkg::REG_TOTAL_BLOCKS);

    assign busy           = (r_state != S_IDLE);
    assign accept         = start && !busy;
    assign o_done         = r_done;
    assign o_result_block = r_result;
    assign o_status       = r_status;

    assign count = (CW'(r_total) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(r_total);
    assign base  = {r_chk, {BIT_W{1'b0}}};
    assign rem   = $signed({1'b0, count}) - $signed({1'b0, CW'(base)});
    assign last  = (rem <= $signed((CW+1)'(WORD_BITS)));
    assign req_blk = BLK_W'(i_block_number);

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            valid_m[b] = (rem > $signed((CW+1)'(b)));
        end
        free_v = ~r_rdata & valid_m;
        found  = |free_v;
        idx    = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_v[b]) begin
                idx = BIT_W'(b);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_chk    = r_chk;
        n_bit    = r_bit;
        n_done   = 1'b0;
        n_result = r_result;
        n_status = r_status;
        mem_we   = 1'b0;
        mem_wa   = r_chk;
        mem_wd   = '0;
        mem_re   = 1'b0;
        mem_ra   = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + 1'b1;
                if (r_clr == WA'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == bba_pkg::OP_ALLOC) begin
                        mem_re  = 1'b1;
                        mem_ra  = '0;
                        n_chk   = '0;
                        n_state = S_SCAN;
                    end else if (i_block_number == '0
                                 || CW'(i_block_number) >= count) begin
                        n_done   = 1'b1;
                        n_result = '0;
                        n_status = bba_pkg::ST_OUT_OF_RANGE;
                    end else begin
                        mem_re  = 1'b1;
                        mem_ra  = req_blk[BLK_W-1:BIT_W];
                        n_chk   = req_blk[BLK_W-1:BIT_W];
                        n_bit   = req_blk[BIT_W-1:0];
                        n_state = S_FCHK;
                    end
                end
            end
            S_SCAN: begin
                if (found) begin
                    mem_we   = 1'b1;
                    mem_wd   = r_rdata | ({{(WORD_BITS-1){1'b0}}, 1'b1} << idx);
                    n_done   = 1'b1;
                    n_result = bba_pkg::BLK_NUM_W'({r_chk, idx});
                    n_status = bba_pkg::ST_OK;
                    n_state  = S_IDLE;
                end else if (last) begin
                    n_done   = 1'b1;
                    n_result = '0;
                    n_status = bba_pkg::ST_OUT_OF_BLOCKS;
                    n_state  = S_IDLE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_chk + 1'b1;
                    n_chk  = r_chk + 1'b1;
                end
            end
            S_FCHK: begin
                n_done   = 1'b1;
                n_result = '0;
                n_state  = S_IDLE;
                if (!r_rdata[r_bit]) begin
                    n_status = bba_pkg::ST_ALREADY_FREE;
                end else begin
                    mem_we   = 1'b1;
                    mem_wd   = r_rdata & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << r_bit);
                    n_status = bba_pkg::ST_OK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // bitmap memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
            r_total <= bba_pkg::TOTAL_RESET;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
            if (cfg_wr) begin
                r_total <= pwdata[bba_pkg::TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk    <= n_chk;
        r_bit    <= n_bit;
        r_result <= n_result;
        r_status <= n_status;
    end

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == bba_pkg::ST_OUT_OF_BLOCKS) |-> (o_result_block == '0))
        else $error("failed allocation returned nonzero block");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != S_IDLE))
        else $error("bitmap write while idle");

    a_dfree_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == bba_pkg::ST_ALREADY_FREE) |-> ($past(r_state) == S_FCHK))
        else $error("double free reported outside free check");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == bba_pkg::OP_ALLOC) |=> (r_state == S_SCAN))
        else $error("allocate did not start a scan");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: self-checking bench for bitmap_block_allocator, first-fit allocate and free
// a bitmap predictor checks every result word; the block count is changed over apb
// depends on bba_pkg and the bitmap_block_allocator rtl
module tb_top;

    localparam int RUN_LIMIT    = 1000000;
    localparam int TAIL_CYCLES  = 140;
    localparam int PRINT_LIMIT  = 100;
    localparam logic [bba_pkg::APB_ADDR_W-1:0] COUNT_ADDR =
        {bba_pkg::REG_TOTAL_BLOCKS, 2'b00};

    typedef struct packed {
        logic [bba_pkg::BLK_NUM_W-1:0] num;
        logic [bba_pkg::STATUS_W-1:0]  code;
    } t_alloc_reply;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [bba_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bba_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bba_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           start = 1'b0;
    logic                           busy;
    logic                           i_opcode = bba_pkg::OP_ALLOC;
    logic [bba_pkg::BLK_NUM_W-1:0]  i_block_number = '0;
    logic                           o_done;
    logic [bba_pkg::BLK_NUM_W-1:0]  o_result_block;
    logic [bba_pkg::STATUS_W-1:0]   o_status;

    bit                             used_map [bba_pkg::MAX_BLOCKS_DEF];
    logic [bba_pkg::TOTAL_W-1:0]    block_count_reg = bba_pkg::TOTAL_RESET;
    logic [bba_pkg::BLK_NUM_W-1:0]  held_blocks [$];
    t_alloc_reply                   replies_due [$];
    int                             errors = 0;
    int unsigned                    cycles = 0;

    bitmap_block_allocator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_block_number (i_block_number),
        .o_done         (o_done),
        .o_result_block (o_result_block),
        .o_status       (o_status)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic int active_blocks();
        return (block_count_reg > bba_pkg::MAX_BLOCKS_DEF) ? bba_pkg::MAX_BLOCKS_DEF
                                                           : int'(block_count_reg);
    endfunction

    function automatic void grant_model(input logic op,
                                        input logic [bba_pkg::BLK_NUM_W-1:0] num,
                                        output t_alloc_reply r);
        int count;
        int i;
        int k;
        count = active_blocks();
        r.num = '0;
        if (op == bba_pkg::OP_ALLOC) begin
            r.code = bba_pkg::ST_OUT_OF_BLOCKS;
            for (i = 0; i < count; i++) begin
                if (!used_map[i]) begin
                    used_map[i] = 1'b1;
                    r.num = i[bba_pkg::BLK_NUM_W-1:0];
                    r.code = bba_pkg::ST_OK;
                    held_blocks.push_back(r.num);
                    break;
                end
            end
        end else if (num == 0 || num >= count) begin
            r.code = bba_pkg::ST_OUT_OF_RANGE;
        end else if (!used_map[num]) begin
            r.code = bba_pkg::ST_ALREADY_FREE;
        end else begin
            used_map[num] = 1'b0;
            r.code = bba_pkg::ST_OK;
            for (k = 0; k < held_blocks.size(); k++) begin
                if (held_blocks[k] == num) begin
                    held_blocks.delete(k);
                    break;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_alloc_reply want;
        if (i_rst_n === 1'b1 && o_done !== 1'b0) begin
            if (replies_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected word: block %0d status %0d",
                                        o_result_block, o_status));
            end else begin
                want = replies_due.pop_front();
                if (o_result_block !== want.num || o_status !== want.code)
                    flag_mismatch($sformatf("block %0d status %0d, want block %0d status %0d",
                                            o_result_block, o_status, want.num, want.code));
            end
        end
    end

    task automatic issue_request(input logic op, input logic [bba_pkg::BLK_NUM_W-1:0] num);
        t_alloc_reply r;
        start <= 1'b1;
        i_opcode <= op;
        i_block_number <= num;
        do @(posedge i_clk); while (busy !== 1'b0);
        grant_model(op, num, r);
        replies_due.push_back(r);
    endtask

    task automatic pause_sender(input int n);
        start <= 1'b0;
        repeat (n) begin
            i_opcode <= 1'($urandom_range(0, 1));
            i_block_number <= bba_pkg::BLK_NUM_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic set_block_count(input logic [bba_pkg::APB_DATA_W-1:0] wdata);
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= COUNT_ADDR;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        block_count_reg = wdata[bba_pkg::TOTAL_W-1:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[bba_pkg::TOTAL_W-1:0] !== block_count_reg)
            flag_mismatch($sformatf("block count reads %0d, want %0d",
                                    prdata[bba_pkg::TOTAL_W-1:0], block_count_reg));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_first_fit_and_block_zero();
        issue_request(bba_pkg::OP_FREE, 12'd0);
        issue_request(bba_pkg::OP_ALLOC, 12'hfff);
        issue_request(bba_pkg::OP_ALLOC, 12'd0);
        issue_request(bba_pkg::OP_ALLOC, 12'h555);
        issue_request(bba_pkg::OP_FREE, 12'd0);
        issue_request(bba_pkg::OP_FREE, 12'd4095);
    endtask

    task automatic test_double_free();
        issue_request(bba_pkg::OP_FREE, 12'd1);
        issue_request(bba_pkg::OP_FREE, 12'd1);
        issue_request(bba_pkg::OP_ALLOC, 12'haaa);
    endtask

    task automatic test_zero_count();
        set_block_count(32'd0);
        issue_request(bba_pkg::OP_ALLOC, 12'd0);
        issue_request(bba_pkg::OP_FREE, 12'd1);
        issue_request(bba_pkg::OP_FREE, 12'd4095);
    endtask

    task automatic test_exhaustion();
        set_block_count(32'd3);
        issue_request(bba_pkg::OP_ALLOC, 12'd0);
        issue_request(bba_pkg::OP_FREE, 12'd3);
        issue_request(bba_pkg::OP_FREE, 12'd2);
        issue_request(bba_pkg::OP_ALLOC, 12'd7);
        issue_request(bba_pkg::OP_ALLOC, 12'd7);
        set_block_count(32'd1);
        issue_request(bba_pkg::OP_ALLOC, 12'd0);
    endtask

    task automatic test_oversized_count();
        set_block_count(32'h0000_1fff);
        issue_request(bba_pkg::OP_FREE, 12'd4095);
        issue_request(bba_pkg::OP_ALLOC, 12'd0);
        set_block_count(32'habcd_1000);
        issue_request(bba_pkg::OP_ALLOC, 12'd0);
    endtask

    task automatic test_count_change();
        set_block_count(32'd2);
        issue_request(bba_pkg::OP_FREE, 12'd2);
        issue_request(bba_pkg::OP_ALLOC, 12'd0);
        set_block_count(32'd4096);
        issue_request(bba_pkg::OP_FREE, 12'd2);
        issue_request(bba_pkg::OP_FREE, 12'd3);
        issue_request(bba_pkg::OP_FREE, 12'd4);
    endtask

    task automatic random_phase(input logic [bba_pkg::APB_DATA_W-1:0] count_word,
                                input int items, input int alloc_pct, input bit idle_on);
        int n;
        int pick;
        int count;
        bit quiet;
        logic [bba_pkg::BLK_NUM_W-1:0] num;
        set_block_count(count_word);
        quiet = 1'b0;
        for (n = 0; n < items; n++) begin
            if (n % 16 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (idle_on && !quiet && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 7));
            count = active_blocks();
            if ($urandom_range(0, 99) < alloc_pct) begin
                num = bba_pkg::BLK_NUM_W'($urandom);
                issue_request(bba_pkg::OP_ALLOC, num);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6 && held_blocks.size() != 0)
                    num = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
                else if (pick < 8)
                    num = (count > 1) ? bba_pkg::BLK_NUM_W'($urandom_range(1, count - 1))
                                      : '0;
                else
                    num = bba_pkg::BLK_NUM_W'($urandom);
                issue_request(bba_pkg::OP_FREE, num);
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(32'd4096, 90, 60, 1'b1);
        random_phase(32'd1, 30, 50, 1'b1);
        random_phase(32'd40, 80, 55, 1'b1);
        random_phase({16'($urandom_range(0, 16'hffff)), 3'b000, 13'h1fff}, 60, 60, 1'b1);
        random_phase(32'd300, 120, 65, 1'b1);
        random_phase(32'd0, 20, 50, 1'b1);
        random_phase($urandom_range(1, 4096), 90, 55, 1'b1);
        random_phase(32'd64, 80, 50, 1'b0);
        random_phase(32'd4095, 80, 50, 1'b0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_fit_and_block_zero();
        test_double_free();
        test_zero_count();
        test_exhaustion();
        test_oversized_count();
        test_count_change();
        test_random_traffic();
        start <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/bba_pkg.sv
rtl/bitmap_block_allocator.sv
tb/sv/tb_top.sv
